// ===== hw/rtl/sdx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types and character constants for the sentence deframer.
// ----------------------------------------------------------------------------
package sdx_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam int DELAY_DEPTH = 5;
	localparam int MIN_FRAME   = 10;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_CSUM = 2'd1;
	localparam logic [1:0] STAT_LONG = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STAT = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// work for one received byte: an optional released byte, then an optional status
	typedef struct packed {
		logic       rel;
		logic [7:0] rel_data;
		logic       rel_first;
		logic       stat;
		logic [1:0] stat_code;
		logic [7:0] stat_len;
	} op_t;

	// {valid, value} of an ASCII hex digit, either case
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sdx_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_front
// Accepts received bytes, tracks framing, delay line and running XOR, and
// hands one work record per byte that produces results to the queue.
// ----------------------------------------------------------------------------
module sdx_front #(
	parameter int MAX_LEN = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         q_full,
	output logic              op_valid,
	output sdx_pkg::op_t      op
);
	import sdx_pkg::*;

	logic       in_frame_q;
	logic [7:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] dly_q [DELAY_DEPTH];

	logic       accept;
	logic       is_start;
	logic       store;
	logic       rel;
	logic [7:0] pos_n;
	logic [7:0] xor_n;
	logic [4:0] hex_hi;
	logic [4:0] hex_lo;
	logic       frame_end;
	logic       csum_ok;
	logic       too_long;

	assign accept   = push & ~q_full;
	assign is_start = rx_byte == CH_DOLLAR;
	assign store    = accept & ~is_start & in_frame_q;

	always_comb begin
		rel       = pos_q >= 8'(DELAY_DEPTH);
		pos_n     = pos_q + 8'd1;
		xor_n     = rel ? (xor_q ^ dly_q[0]) : xor_q;
		hex_hi    = hex_digit(dly_q[2]);
		hex_lo    = hex_digit(dly_q[3]);
		// before the shift the trailer sits at dly_q[1..4] plus the new byte
		frame_end = (pos_n >= 8'(MIN_FRAME)) && (dly_q[4] == CH_CR) && (rx_byte == CH_LF);
		csum_ok   = (dly_q[1] == CH_STAR) && hex_hi[4] && hex_lo[4] &&
		            ({hex_hi[3:0], hex_lo[3:0]} == xor_n);
		too_long  = ~frame_end && (pos_n >= 8'(MAX_LEN));

		op.rel       = rel;
		op.rel_data  = dly_q[0];
		op.rel_first = pos_q == 8'(DELAY_DEPTH);
		op.stat      = frame_end | too_long;
		op.stat_code = frame_end ? (csum_ok ? STAT_OK : STAT_CSUM) : STAT_LONG;
		op.stat_len  = pos_n - 8'(DELAY_DEPTH);
	end

	assign op_valid = store & (op.rel | op.stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 8'd0;
			xor_q      <= 8'd0;
		end else if (accept) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				pos_q      <= 8'd0;
				xor_q      <= 8'd0;
			end else if (in_frame_q) begin
				xor_q <= xor_n;
				if (op.stat) begin
					in_frame_q <= 1'b0;
					pos_q      <= 8'd0;
				end else begin
					pos_q <= pos_n;
				end
			end
		end
	end

	// delay line holds the last five stored bytes; the trailer never leaves it
	always_ff @(posedge clk) begin
		if (store) begin
			for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
				dly_q[i] <= dly_q[i + 1];
			end
			dly_q[DELAY_DEPTH - 1] <= rx_byte;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 8'(MAX_LEN))
		else $error("frame position reached the length limit");
	a_out_of_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> pos_q == 8'd0)
		else $error("position nonzero outside a frame");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op.stat) |=> (!in_frame_q && pos_q == 8'd0) || in_frame_q)
		else $error("frame end left position set");
	a_first_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && op.rel_first) |-> op.rel)
		else $error("first mark without a released byte");

endmodule
`default_nettype wire

// ===== hw/rtl/sdx_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_queue
// Short queue of work records between the front and back parts.
// ----------------------------------------------------------------------------
module sdx_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire sdx_pkg::op_t wr_op,
	output logic              full,
	input  wire logic         rd,
	output sdx_pkg::op_t      head,
	output logic              q_empty
);
	import sdx_pkg::*;

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~q_empty;
	assign head    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == cnt_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> !q_empty)
		else $error("queue empty after a write");

endmodule
`default_nettype wire

// ===== hw/rtl/sdx_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_back
// Expands each work record into one or two results and holds the oldest
// result in an output register until its transfer.
// ----------------------------------------------------------------------------
module sdx_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire sdx_pkg::op_t head,
	input  wire logic         q_empty,
	output logic              q_rd,
	input  wire logic         pop,
	output logic              empty,
	output logic              kind,
	output logic [7:0]        data,
	output logic              first,
	output logic [1:0]        status,
	output logic [7:0]        length,
	output logic              last
);
	import sdx_pkg::*;

	logic       vld_q;
	logic       phase_q;   // released byte of the head record already sent
	logic       kind_q;
	logic [7:0] data_q;
	logic       first_q;
	logic [1:0] status_q;
	logic [7:0] length_q;
	logic       last_q;
	logic       load;
	logic       send_rel;

	assign load     = ~q_empty & (~vld_q | pop);
	assign send_rel = ~phase_q & head.rel;
	assign q_rd     = load & ~(send_rel & head.stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q   <= 1'b1;
				phase_q <= send_rel & head.stat;
			end else if (pop) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_rel) begin
				kind_q   <= KIND_DATA;
				data_q   <= head.rel_data;
				first_q  <= head.rel_first;
				status_q <= STAT_OK;
				length_q <= 8'd0;
				last_q   <= ~head.stat;
			end else begin
				kind_q   <= KIND_STAT;
				data_q   <= 8'd0;
				first_q  <= 1'b0;
				status_q <= head.stat_code;
				length_q <= head.stat_len;
				last_q   <= 1'b1;
			end
		end
	end

	assign empty  = ~vld_q;
	assign kind   = kind_q;
	assign data   = data_q;
	assign first  = first_q;
	assign status = status_q;
	assign length = length_q;
	assign last   = last_q;

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!q_empty && head.rel && head.stat))
		else $error("split record lost from queue head");
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q == KIND_STAT) |-> (last_q && data_q == 8'd0))
		else $error("status result malformed");
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && kind_q == KIND_DATA) |-> (status_q == STAT_OK && length_q == 8'd0))
		else $error("data result carries status fields");

endmodule
`default_nettype wire

// ===== hw/rtl/sentence_deframer_xor_check.sv =====
`default_nettype none
// A byte's work record goes into the queue, then is loaded into the output register.
// Bytes enter at one per cycle unless the queue is full; results leave at one per
// cycle on pop, so a byte releasing a payload byte and ending a frame gives two results.
// A four-entry work queue lets input continue while the output is stalled.
// Reset clears framing state, queue and output valid; the delay line is not reset.
// ----------------------------------------------------------------------------
// sentence_deframer_xor_check
// Deframes '$payload*HH\r\n' sentences, releases payload bytes and reports
// frame status with an XOR checksum check.
// ----------------------------------------------------------------------------
module sentence_deframer_xor_check #(
	parameter int MAX_LEN = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic            kind,
	output logic [7:0]      data,
	output logic            first,
	output logic [1:0]      status,
	output logic [7:0]      length,
	output logic            last
);
	import sdx_pkg::*;

	logic op_valid;
	op_t  op;
	op_t  head;
	logic q_empty;
	logic q_rd;

	sdx_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.op_valid (op_valid),
		.op       (op)
	);

	sdx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (op_valid),
		.wr_op   (op),
		.full    (full),
		.rd      (q_rd),
		.head    (head),
		.q_empty (q_empty)
	);

	sdx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.kind    (kind),
		.data    (data),
		.first   (first),
		.status  (status),
		.length  (length),
		.last    (last)
	);

endmodule
`default_nettype wire
